FILE: hdl/pcom_pkg.sv
package pcom_pkg;

    localparam int NUM_SENSORS_DEF = 16;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int INDEX_W     = 4;
    localparam int SAMPLE_W    = 12;
    localparam int MASS_W      = 16;
    localparam int COORD_W     = 16;
    localparam int SUM_W       = 32;
    localparam int POS_W       = 16;
    localparam int TABLE_DEPTH = 16;
    localparam int QUEUE_DEPTH = 4;

    // x in the upper half, y in the lower half, both Q0.16
    localparam logic [31:0] POS_TABLE [TABLE_DEPTH] = '{
        {16'd41849, 16'd7986},  {16'd23261, 16'd10421},
        {16'd48841, 16'd13722}, {16'd30998, 16'd16021},
        {16'd14266, 16'd17777}, {16'd44835, 16'd20051},
        {16'd29122, 16'd22450}, {16'd13493, 16'd25416},
        {16'd33943, 16'd29595}, {16'd12509, 16'd32265},
        {16'd30429, 16'd43935}, {16'd12649, 16'd43762},
        {16'd30429, 16'd49597}, {16'd12649, 16'd49448},
        {16'd30569, 16'd59832}, {16'd13036, 16'd59857}
    };

    typedef struct packed {
        logic [POS_W:0]      px;
        logic [POS_W-1:0]    py;
        logic [SAMPLE_W-1:0] smp;
        logic                last;
    } queue_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

FILE: hdl/pressure_center_of_mass.sv
// channel  | direction | handshake          | payload
// s_       | in        | s_valid / s_ready  | s_sensor_index, s_sample
// m_       | out       | m_valid / m_ready  | m_total_mass, m_center_x, m_center_y
// cfg      | in        | cfg_wr_en          | cfg_wr_data (right_side)
//
// samples enter one per cycle while the 4-deep queue has room; the back end takes each
// sample through a multiply state and then an accumulate state before it takes the next
// frame end adds a restoring division over all 32 + FRAC_BITS numerator bits, then loads the result
// reset (aresetn low, synchronous) empties the queue, clears the sums and right_side
// a held result stalls only the next frame end; samples keep flowing until the queue fills
module pressure_center_of_mass #(
    parameter int NUM_SENSORS = pcom_pkg::NUM_SENSORS_DEF,
    parameter int SAMPLE_BITS = pcom_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = pcom_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pcom_pkg::INDEX_W-1:0] s_sensor_index,
    input  logic [pcom_pkg::SAMPLE_W-1:0] s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pcom_pkg::MASS_W-1:0]  m_total_mass,
    output logic [pcom_pkg::COORD_W-1:0] m_center_x,
    output logic [pcom_pkg::COORD_W-1:0] m_center_y
);
    import pcom_pkg::*;

    queue_entry_t push_entry;
    queue_entry_t head_entry;
    logic         push;
    logic         pop;
    logic         q_empty;
    logic         q_full;

    pcom_front #(
        .NUM_SENSORS (NUM_SENSORS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_index (s_sensor_index),
        .s_sample       (s_sample),
        .q_full         (q_full),
        .q_push         (push),
        .q_entry        (push_entry)
    );

    pcom_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    pcom_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_entry   (head_entry),
        .q_empty      (q_empty),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_total_mass (m_total_mass),
        .m_center_x   (m_center_x),
        .m_center_y   (m_center_y)
    );

endmodule

FILE: hdl/pcom_front.sv
module pcom_front #(
    parameter int NUM_SENSORS = pcom_pkg::NUM_SENSORS_DEF,
    parameter int SAMPLE_BITS = pcom_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pcom_pkg::INDEX_W-1:0]  s_sensor_index,
    input  logic [pcom_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          q_full,
    output logic                          q_push,
    output pcom_pkg::queue_entry_t        q_entry
);
    import pcom_pkg::*;

    localparam int SMP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((32'd1 << SMP_W) - 32'd1);

    logic              right_side_reg;
    logic [31:0]       pos_entry;
    logic [POS_W:0]    px_raw;
    logic              in_range;
    logic              is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_side_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            right_side_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        pos_entry = POS_TABLE[s_sensor_index];
        px_raw    = {1'b0, pos_entry[31:16]};
        in_range  = 32'(s_sensor_index) < NUM_SENSORS;
        is_last   = 32'(s_sensor_index) == (NUM_SENSORS - 1);

        q_entry.px   = right_side_reg ? ((POS_W+1)'(1 << POS_W) - px_raw) : px_raw;
        q_entry.py   = pos_entry[15:0];
        q_entry.smp  = s_sample & SMP_MASK;
        q_entry.last = is_last;

        // out-of-range indices are taken and dropped
        s_ready = !q_full;
        q_push  = s_valid && s_ready && in_range;
    end

endmodule

FILE: hdl/pcom_queue.sv
module pcom_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  pcom_pkg::queue_entry_t push_entry,
    input  logic                   pop,
    output pcom_pkg::queue_entry_t head_entry,
    output logic                   empty,
    output logic                   full
);
    import pcom_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty      = count_reg == '0;
    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    no_overflow_a: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |-> !push) else $error("queue written while full");
    no_underflow_a: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue read while empty");
    count_track_a: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && !full |=> !empty) else $error("queue count lost an entry");

endmodule

FILE: hdl/pcom_back.sv
module pcom_back #(
    parameter int FRAC_BITS = pcom_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pcom_pkg::queue_entry_t       head_entry,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pcom_pkg::MASS_W-1:0]  m_total_mass,
    output logic [pcom_pkg::COORD_W-1:0] m_center_x,
    output logic [pcom_pkg::COORD_W-1:0] m_center_y
);
    import pcom_pkg::*;

    localparam int NW    = SUM_W + FRAC_BITS;
    localparam int CW    = $clog2(NW + 1);
    localparam int PX_PW = POS_W + 1 + SAMPLE_W;
    localparam int PY_PW = POS_W + SAMPLE_W;

    back_state_t         state_reg, state_next;
    logic [PX_PW-1:0]    prodx_reg, prodx_next;
    logic [PY_PW-1:0]    prody_reg, prody_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                last_reg, last_next;
    logic [MASS_W-1:0]   mass_reg, mass_next;
    logic [SUM_W-1:0]    xsum_reg, xsum_next;
    logic [SUM_W-1:0]    ysum_reg, ysum_next;
    logic [NW-1:0]       numx_reg, numx_next;
    logic [NW-1:0]       numy_reg, numy_next;
    logic [NW-1:0]       qx_reg, qx_next;
    logic [NW-1:0]       qy_reg, qy_next;
    logic [SUM_W-1:0]    remx_reg, remx_next;
    logic [SUM_W-1:0]    remy_reg, remy_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [MASS_W-1:0]   out_mass_reg, out_mass_next;
    logic [COORD_W-1:0]  out_x_reg, out_x_next;
    logic [COORD_W-1:0]  out_y_reg, out_y_next;

    logic [MASS_W:0]     mass_add;
    logic [SUM_W:0]      xsum_add;
    logic [SUM_W:0]      ysum_add;
    logic [MASS_W-1:0]   mass_acc;
    logic [SUM_W-1:0]    xsum_acc;
    logic [SUM_W-1:0]    ysum_acc;
    logic [SUM_W:0]      den;
    logic [SUM_W:0]      trial_x, trial_y;
    logic [SUM_W:0]      diff_x, diff_y;
    logic                ge_x, ge_y;
    logic                out_free;

    assign m_valid      = m_valid_reg;
    assign m_total_mass = out_mass_reg;
    assign m_center_x   = out_x_reg;
    assign m_center_y   = out_y_reg;

    always_comb begin
        mass_add = {1'b0, mass_reg} + (MASS_W+1)'(smp_reg);
        xsum_add = {1'b0, xsum_reg} + (SUM_W+1)'(prodx_reg);
        ysum_add = {1'b0, ysum_reg} + (SUM_W+1)'(prody_reg);
        mass_acc = mass_add[MASS_W] ? '1 : mass_add[MASS_W-1:0];
        xsum_acc = xsum_add[SUM_W] ? '1 : xsum_add[SUM_W-1:0];
        ysum_acc = ysum_add[SUM_W] ? '1 : ysum_add[SUM_W-1:0];

        den     = {1'b0, mass_reg, 16'd0};
        trial_x = {remx_reg, numx_reg[NW-1]};
        trial_y = {remy_reg, numy_reg[NW-1]};
        diff_x  = trial_x - den;
        diff_y  = trial_y - den;
        ge_x    = trial_x >= den;
        ge_y    = trial_y >= den;

        out_free = !m_valid_reg || m_ready;

        state_next    = state_reg;
        prodx_next    = prodx_reg;
        prody_next    = prody_reg;
        smp_next      = smp_reg;
        last_next     = last_reg;
        mass_next     = mass_reg;
        xsum_next     = xsum_reg;
        ysum_next     = ysum_reg;
        numx_next     = numx_reg;
        numy_next     = numy_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        remx_next     = remx_reg;
        remy_next     = remy_reg;
        cnt_next      = cnt_reg;
        out_mass_next = out_mass_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        q_pop         = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    prodx_next = PX_PW'(head_entry.px) * PX_PW'(head_entry.smp);
                    prody_next = PY_PW'(head_entry.py) * PY_PW'(head_entry.smp);
                    smp_next   = head_entry.smp;
                    last_next  = head_entry.last;
                    state_next = BK_ACC;
                end
            end
            BK_ACC: begin
                mass_next = mass_acc;
                xsum_next = xsum_acc;
                ysum_next = ysum_acc;
                if (last_reg) begin
                    numx_next  = {xsum_acc, FRAC_BITS'(0)};
                    numy_next  = {ysum_acc, FRAC_BITS'(0)};
                    qx_next    = '0;
                    qy_next    = '0;
                    remx_next  = '0;
                    remy_next  = '0;
                    cnt_next   = '0;
                    state_next = BK_DIV;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV: begin
                numx_next = {numx_reg[NW-2:0], 1'b0};
                numy_next = {numy_reg[NW-2:0], 1'b0};
                qx_next   = {qx_reg[NW-2:0], ge_x};
                qy_next   = {qy_reg[NW-2:0], ge_y};
                remx_next = ge_x ? diff_x[SUM_W-1:0] : trial_x[SUM_W-1:0];
                remy_next = ge_y ? diff_y[SUM_W-1:0] : trial_y[SUM_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    out_mass_next = mass_reg;
                    if (mass_reg == '0) begin
                        out_x_next = '0;
                        out_y_next = '0;
                    end else begin
                        out_x_next = (|qx_reg[NW-1:COORD_W]) ? '1 : qx_reg[COORD_W-1:0];
                        out_y_next = (|qy_reg[NW-1:COORD_W]) ? '1 : qy_reg[COORD_W-1:0];
                    end
                    m_valid_next = 1'b1;
                    mass_next    = '0;
                    xsum_next    = '0;
                    ysum_next    = '0;
                    state_next   = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
            mass_reg    <= '0;
            xsum_reg    <= '0;
            ysum_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mass_reg    <= mass_next;
            xsum_reg    <= xsum_next;
            ysum_reg    <= ysum_next;
        end
    end

    always_ff @(posedge aclk) begin
        prodx_reg    <= prodx_next;
        prody_reg    <= prody_next;
        smp_reg      <= smp_next;
        last_reg     <= last_next;
        numx_reg     <= numx_next;
        numy_reg     <= numy_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        remx_reg     <= remx_next;
        remy_reg     <= remy_next;
        cnt_reg      <= cnt_next;
        out_mass_reg <= out_mass_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
    end

    pop_to_acc_a: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_IDLE && !q_empty |=> state_reg == BK_ACC)
        else $error("queued sample not taken");
    last_starts_div_a: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_ACC && last_reg |=> state_reg == BK_DIV && cnt_reg == '0)
        else $error("frame end did not start division");
    hold_result_a: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_DONE && m_valid_reg && !m_ready |=> state_reg == BK_DONE)
        else $error("result overwrote a pending transaction");
    clear_after_load_a: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_DONE && out_free |=> m_valid_reg && mass_reg == '0
        && xsum_reg == '0 && ysum_reg == '0)
        else $error("sums not cleared after result");

endmodule

FILE: tb/pressure_center_of_mass_tb.sv
`timescale 1ns / 100ps

module pressure_center_of_mass_tb;

    import pcom_pkg::*;

    localparam int LAST_SENSOR  = NUM_SENSORS_DEF - 1;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_OFF     = 400;
    localparam int PHASE_ITEMS  = 350;

    // sensor positions, x in the upper half and y in the lower half, Q0.16
    localparam logic [31:0] SENSOR_POS [16] = '{
        {16'd41849, 16'd7986},  {16'd23261, 16'd10421},
        {16'd48841, 16'd13722}, {16'd30998, 16'd16021},
        {16'd14266, 16'd17777}, {16'd44835, 16'd20051},
        {16'd29122, 16'd22450}, {16'd13493, 16'd25416},
        {16'd33943, 16'd29595}, {16'd12509, 16'd32265},
        {16'd30429, 16'd43935}, {16'd12649, 16'd43762},
        {16'd30429, 16'd49597}, {16'd12649, 16'd49448},
        {16'd30569, 16'd59832}, {16'd13036, 16'd59857}
    };

    typedef struct packed {
        logic [MASS_W-1:0]  mass;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } frame_result_t;

    typedef struct {
        logic [INDEX_W-1:0]  idx;
        logic [SAMPLE_W-1:0] smp;
        bit                  known;
        frame_result_t       want;
    } sample_item_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [INDEX_W-1:0]   s_sensor_index;
    logic [SAMPLE_W-1:0]  s_sample;
    logic                 m_valid;
    logic                 m_ready;
    logic [MASS_W-1:0]    m_total_mass;
    logic [COORD_W-1:0]   m_center_x;
    logic [COORD_W-1:0]   m_center_y;

    // predictor state
    bit                   side_right;
    logic [MASS_W-1:0]    mass_acc;
    logic [SUM_W-1:0]     x_acc;
    logic [SUM_W-1:0]     y_acc;

    frame_result_t        expected_frames [$];
    sample_item_t         stim_items [$];
    frame_result_t        arrived;
    int                   mismatch_count;
    int                   quiet_cycles;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_cycles;
    bit                   ready_next;

    // zero mass, lone last sensor, full frame at max, repeated and missing indices
    sample_item_t directed_rows [24] = '{
        '{4'd15, 12'd0,     1'b1, '{16'd0,    16'd0,     16'd0}},
        '{4'd15, 12'd4095,  1'b1, '{16'd4095, 16'd13036, 16'd59857}},
        '{4'd15, 12'd1,     1'b1, '{16'd1,    16'd13036, 16'd59857}},
        '{4'd0,  12'd4095,  1'b0, '0},
        '{4'd1,  12'd4095,  1'b0, '0},
        '{4'd2,  12'd4095,  1'b0, '0},
        '{4'd3,  12'd4095,  1'b0, '0},
        '{4'd4,  12'd4095,  1'b0, '0},
        '{4'd5,  12'd4095,  1'b0, '0},
        '{4'd6,  12'd4095,  1'b0, '0},
        '{4'd7,  12'd4095,  1'b0, '0},
        '{4'd8,  12'd4095,  1'b0, '0},
        '{4'd9,  12'd4095,  1'b0, '0},
        '{4'd10, 12'd4095,  1'b0, '0},
        '{4'd11, 12'd4095,  1'b0, '0},
        '{4'd12, 12'd4095,  1'b0, '0},
        '{4'd13, 12'd4095,  1'b0, '0},
        '{4'd14, 12'd4095,  1'b0, '0},
        '{4'd15, 12'd4095,  1'b0, '0},
        '{4'd7,  12'd100,   1'b0, '0},
        '{4'd7,  12'd200,   1'b0, '0},
        '{4'd15, 12'd0,     1'b0, '0},
        '{4'd3,  12'hAAA,   1'b0, '0},
        '{4'd15, 12'h555,   1'b0, '0}
    };

    pressure_center_of_mass DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_index (s_sensor_index),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_total_mass   (m_total_mass),
        .m_center_x     (m_center_x),
        .m_center_y     (m_center_y)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic logic [COORD_W-1:0] centroid_of(logic [SUM_W-1:0] wsum,
                                                      logic [MASS_W-1:0] mass);
        logic [63:0] q;
        if (mass == '0) begin
            return '0;
        end
        q = ({32'd0, wsum} << 16) / ({48'd0, mass} << 16);
        return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [63:0] term);
        logic [63:0] s;
        s = {32'd0, acc} + term;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // adds one sample to the frame sums; returns 1 with the frame result at the last sensor
    function automatic bit accumulate_sample(logic [INDEX_W-1:0] idx,
                                             logic [SAMPLE_W-1:0] smp,
                                             output frame_result_t res);
        logic [16:0] px;
        logic [15:0] py;
        logic [16:0] m;
        px = {1'b0, SENSOR_POS[idx][31:16]};
        py = SENSOR_POS[idx][15:0];
        if (side_right) begin
            px = 17'h10000 - px;
        end
        m = {1'b0, mass_acc} + {5'd0, smp};
        mass_acc = (m > 17'hFFFF) ? 16'hFFFF : m[15:0];
        x_acc = sat_sum(x_acc, 64'(px) * 64'(smp));
        y_acc = sat_sum(y_acc, 64'(py) * 64'(smp));
        res = '0;
        if (idx != INDEX_W'(LAST_SENSOR)) begin
            return 1'b0;
        end
        res.mass = mass_acc;
        res.cx   = centroid_of(x_acc, mass_acc);
        res.cy   = centroid_of(y_acc, mass_acc);
        mass_acc = '0;
        x_acc    = '0;
        y_acc    = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string field, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        end
    endtask

    task automatic add_item(logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] smp);
        sample_item_t it;
        it.idx   = idx;
        it.smp   = smp;
        it.known = 1'b0;
        it.want  = '0;
        stim_items.push_back(it);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return 12'hFFF;
        end
        return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    // mostly ordered frames; the rest partial frames, noise and saturating frames
    task automatic gen_traffic(int n_items);
        int count;
        int kind;
        int len;
        count = 0;
        while (count < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                for (int i = 0; i <= LAST_SENSOR; i++) begin
                    add_item(INDEX_W'(i), pick_sample());
                end
                count += LAST_SENSOR + 1;
            end else if (kind < 85) begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    add_item(INDEX_W'($urandom_range(0, LAST_SENSOR - 1)), pick_sample());
                end
                add_item(INDEX_W'(LAST_SENSOR), pick_sample());
                count += len + 1;
            end else if (kind < 93) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    add_item(INDEX_W'($urandom_range(0, LAST_SENSOR)), pick_sample());
                end
                count += len;
            end else begin
                len = $urandom_range(17, 28);
                for (int i = 0; i < len; i++) begin
                    add_item(INDEX_W'($urandom_range(0, LAST_SENSOR - 1)),
                             SAMPLE_W'(($urandom_range(0, 1) != 0) ?
                                       32'hFFF : $urandom_range(3500, 4095)));
                end
                add_item(INDEX_W'(LAST_SENSOR), 12'hFFF);
                count += len + 1;
            end
        end
    endtask

    task automatic take_sample(sample_item_t it);
        frame_result_t res;
        if (accumulate_sample(it.idx, it.smp, res)) begin
            expected_frames.push_back(it.known ? it.want : res);
        end
    endtask

    task automatic drive_items();
        sample_item_t it;
        while (stim_items.size() > 0) begin
            it = stim_items.pop_front();
            @(negedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid        <= 1'b1;
            s_sensor_index <= it.idx;
            s_sample       <= it.smp;
            do @(posedge aclk); while (!s_ready);
            take_sample(it);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_side(bit v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        side_right = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(bit side, int idle_pct, int stall_pct, int n_items);
        write_side(side);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        gen_traffic(n_items);
        drive_items();
        wait_drained();
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            ready_next = 1'b0;
            hold_cycles--;
        end else begin
            ready_next = ($urandom_range(0, 99) >= recv_stall_pct);
        end
        m_ready <= ready_next;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("frame with none pending", m_total_mass, 16'd0);
            end else begin
                arrived = expected_frames.pop_front();
                if (m_total_mass !== arrived.mass) begin
                    report_mismatch("total_mass", m_total_mass, arrived.mass);
                end
                if (m_center_x !== arrived.cx) begin
                    report_mismatch("center_x", m_center_x, arrived.cx);
                end
                if (m_center_y !== arrived.cy) begin
                    report_mismatch("center_y", m_center_y, arrived.cy);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_valid        = 1'b0;
        s_sensor_index = '0;
        s_sample       = '0;
        m_ready        = 1'b0;
        side_right     = 1'b0;
        mass_acc       = '0;
        x_acc          = '0;
        y_acc          = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            stim_items.push_back(directed_rows[i]);
        end
        drive_items();
        wait_drained();

        run_phase(1'b1, 0,  0,  PHASE_ITEMS);
        run_phase(1'b0, 74, 0,  PHASE_ITEMS);
        run_phase(1'b1, 0,  74, PHASE_ITEMS);
        run_phase(1'b0, 20, 20, PHASE_ITEMS);

        // receiver held off while the sender keeps pushing
        write_side(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = HOLD_OFF;
        gen_traffic(64);
        drive_items();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/pcom_pkg.sv
hdl/pcom_front.sv
hdl/pcom_queue.sv
hdl/pcom_back.sv
hdl/pressure_center_of_mass.sv
tb/pressure_center_of_mass_tb.sv
